// ===== sv/crcdf_pkg.sv =====
`default_nettype none
package crcdf_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Operation the controller asks the datapath to perform in the current cycle.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LEN_LO = 3'd1,
    OP_LEN_HI = 3'd2,
    OP_TYPE   = 3'd3,
    OP_BODY   = 3'd4,
    OP_CRC    = 3'd5,
    OP_READ   = 3'd6,
    OP_LOAD   = 3'd7
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic body_done;
    logic crc_done;
    logic crc_ok;
    logic drain_last;
    logic out_free;
  } status_t;

  // One byte of the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/crcdf_ctrl.sv =====
`default_nettype none
module crcdf_ctrl
  import crcdf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_LEN_LO = 7'b000_0001,
    S_LEN_HI = 7'b000_0010,
    S_TYPE   = 7'b000_0100,
    S_BODY   = 7'b000_1000,
    S_CRC    = 7'b001_0000,
    S_READ   = 7'b010_0000,
    S_LOAD   = 7'b100_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign in_tready = (state_r != S_READ) && (state_r != S_LOAD);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_LEN_HI: begin
        if (acc) begin
          cmd.op    = OP_LEN_HI;
          state_nxt = S_TYPE;
        end
      end
      S_TYPE: begin
        if (acc) begin
          cmd.op    = OP_TYPE;
          state_nxt = sts.len_zero ? S_CRC : S_BODY;
        end
      end
      S_BODY: begin
        if (acc) begin
          cmd.op = OP_BODY;
          if (sts.body_done) begin
            state_nxt = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (acc) begin
          cmd.op = OP_CRC;
          if (sts.crc_done) begin
            if (!sts.crc_ok) begin
              state_nxt = S_LEN_LO;
            end else if (sts.len_zero) begin
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op = OP_LOAD;
        if (sts.out_free) begin
          state_nxt = sts.drain_last ? S_LEN_LO : S_READ;
        end
      end
      default: begin
        // First length byte; also covers any state code that is not defined.
        if (acc) begin
          cmd.op    = OP_LEN_LO;
          state_nxt = S_LEN_HI;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LEN_LO;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/crcdf_dp.sv =====
`default_nettype none
module crcdf_dp
  import crcdf_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  wire cmd_t        cmd,
  output status_t          sts,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  output logic [0:0]       out_tuser,
  output logic             out_tlast
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);

  logic [7:0]    store_r [PAYLOAD_DEPTH];
  logic [7:0]    rd_data_r;

  logic [15:0]   frame_len_r, frame_len_nxt;
  logic [7:0]    frame_kind_r, frame_kind_nxt;
  logic [15:0]   byte_cnt_r, byte_cnt_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rx_crc_r, rx_crc_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_type_r;
  logic [6:0]    out_len_r;
  logic          out_has_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic [31:0]   crc_step;
  logic [16:0]   cnt_inc;
  logic          wr_en;
  logic          load;

  assign crc_step = crc_byte(crc_r, in_byte);
  assign cnt_inc  = {1'b0, byte_cnt_r} + 17'd1;

  assign sts.len_zero   = (frame_len_r == 16'd0);
  assign sts.body_done  = (cnt_inc >= {1'b0, frame_len_r});
  assign sts.crc_done   = (byte_cnt_r == 16'd3);
  // The fourth CRC byte is still on the input when the check is made.
  assign sts.crc_ok     = ({in_byte, rx_crc_r[23:0]} == ~crc_r) &&
                          (frame_len_r <= 16'(PAYLOAD_DEPTH));
  assign sts.drain_last = sts.len_zero || ((16'(rd_idx_r) + 16'd1) == frame_len_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign wr_en = (cmd.op == OP_BODY) && (byte_cnt_r < 16'(PAYLOAD_DEPTH));
  assign load  = (cmd.op == OP_LOAD) && sts.out_free;

  always_comb begin
    frame_len_nxt  = frame_len_r;
    frame_kind_nxt = frame_kind_r;
    byte_cnt_nxt   = byte_cnt_r;
    crc_nxt        = crc_r;
    rx_crc_nxt     = rx_crc_r;
    rd_idx_nxt     = rd_idx_r;
    case (cmd.op)
      OP_LEN_LO: begin
        frame_len_nxt = {8'h00, in_byte};
        crc_nxt       = crc_step;
      end
      OP_LEN_HI: begin
        frame_len_nxt = {in_byte, frame_len_r[7:0]};
        crc_nxt       = crc_step;
      end
      OP_TYPE: begin
        frame_kind_nxt = in_byte;
        crc_nxt        = crc_step;
        byte_cnt_nxt   = 16'd0;
      end
      OP_BODY: begin
        crc_nxt      = crc_step;
        byte_cnt_nxt = sts.body_done ? 16'd0 : cnt_inc[15:0];
      end
      OP_CRC: begin
        if (sts.crc_done) begin
          byte_cnt_nxt = 16'd0;
          crc_nxt      = CRC_ONES;
          rx_crc_nxt   = 32'd0;
          rd_idx_nxt   = '0;
        end else begin
          byte_cnt_nxt = cnt_inc[15:0];
          rx_crc_nxt   = rx_crc_r | ({24'h00_0000, in_byte} << {byte_cnt_r[1:0], 3'b000});
        end
      end
      OP_LOAD: begin
        if (load) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= 16'd0;
      frame_kind_r <= 8'd0;
      byte_cnt_r   <= 16'd0;
      crc_r        <= CRC_ONES;
      rx_crc_r     <= 32'd0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      frame_len_r  <= frame_len_nxt;
      frame_kind_r <= frame_kind_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      crc_r        <= crc_nxt;
      rx_crc_r     <= rx_crc_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[byte_cnt_r[AW-1:0]] <= in_byte;
    end
    if (cmd.op == OP_READ) begin
      rd_data_r <= store_r[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_type_r <= frame_kind_r;
      out_len_r  <= frame_len_r[6:0];
      out_has_r  <= !sts.len_zero;
      out_byte_r <= sts.len_zero ? 8'h00 : rd_data_r;
      out_last_r <= sts.drain_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_byte_r, out_len_r, out_type_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/crc32_frame_deframer_core.sv =====
`default_nettype none
// Length-prefixed frame parser with CRC-32 check.
// The in_ channel carries one received byte per request. A frame is a
// little-endian 16-bit payload length, a type byte, the payload and a
// little-endian CRC-32 over header and payload. Every byte is taken as soon
// as offered while the frame arrives; payload goes into an internal buffer.
// When the last CRC byte of a good frame is taken, in_tready drops and the
// payload is read back from the buffer and sent on the out_ channel, one
// request per byte, last byte marked by out_tlast. For each byte the
// controller first reads the buffer into a data register, then loads the
// output register once it is free, and the input stays blocked until the
// last byte is loaded. An empty frame gives a single result with out_tuser
// low, loaded without a buffer read.
// Frames with a bad CRC, or longer than the buffer, are read in full and
// dropped. A stalled receiver holds the drain; the final result may wait
// in the output register while parsing of the next frame goes on.
// Reset clears the parser to expect a length byte and empties the output.
module crc32_frame_deframer_core
  import crcdf_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] frame_type, [14:8] frame_length,
                                       // [22:15] payload_byte, [23] zero
  output logic [0:0]       out_tuser,  // [0] has_byte
  output logic             out_tlast
);

  cmd_t    cmd;
  status_t sts;

  crcdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crcdf_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== sv/crcdf_chk.sv =====
`default_nettype none
module crcdf_chk
  import crcdf_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result without a byte (empty frame) is marked last, with zero length.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata[22:8] == 15'd0))
    else $error("bad empty-frame result");

  // While a frame is still being drained the parser takes no input.
  a_drain_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during drain");

  // Only frames that fit the buffer are delivered.
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:8] <= 7'(PAYLOAD_DEPTH)) && !out_tdata[23])
    else $error("delivered length out of range");

endmodule

bind crc32_frame_deframer_core crcdf_chk #(
  .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
) u_crcdf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
